// File: rtl/tacdf_pkg.sv
// ----------------------------------------------------------------------------
// Triangle area CDF builder package
// Shared widths, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tacdf_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int COORD_BITS    = 12;
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int TOT_W         = 36;
    localparam int FRAC_W        = 17;
    localparam int DIF_W         = COORD_BITS + 1;
    localparam int CRS_W         = 2 * DIF_W + 1;
    localparam int SUM_W         = 2 * CRS_W + 2;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO_TOT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_SQ,
        S_SQRT,
        S_ACCUM,
        S_RDMEM,
        S_DIV,
        S_DONE
    } state_t;

    // Handshake between the sequencer and the shared arithmetic unit.
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } unit_ctl_t;

endpackage

// File: rtl/tacdf_unit.sv
// ----------------------------------------------------------------------------
// Triangle area CDF shared iterative unit
// One subtract-and-compare datapath, used one bit per cycle for both the
// integer square root and the restoring division.
// ----------------------------------------------------------------------------
module tacdf_unit
    import tacdf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  unit_ctl_t           ctl,
    input  logic [SUM_W-1:0]    radicand,
    input  logic [TOT_W-1:0]    dividend,
    input  logic [TOT_W-1:0]    divisor,
    output logic                busy,
    output logic [SUM_W-1:0]    result
);

    localparam int REM_W  = SUM_W + 2;
    localparam int QW     = TOT_W + 16;
    localparam int STEP_W = 6;

    logic              busy_reg, busy_next;
    logic              mode_reg, mode_next;      // high for division
    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  num_reg, num_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  sub_op;

    // Square root: two radicand bits enter per step, compared against 4q+1.
    // Division: one dividend bit enters per step, compared against the divisor.
    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[REM_W-2:0], num_reg[SUM_W-1]};
            sub_op  = REM_W'(divisor);
        end
        else
        begin
            shifted = {rem_reg[REM_W-3:0], num_reg[SUM_W-1:SUM_W-2]};
            sub_op  = {q_reg[REM_W-3:0], 2'b01};
        end
        trial = shifted - sub_op;
    end

    always_comb
    begin
        busy_next = busy_reg;
        mode_next = mode_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        if (ctl.start_sqrt)
        begin
            busy_next = 1'b1;
            mode_next = 1'b0;
            step_next = STEP_W'(SUM_W / 2);
            rem_next  = '0;
            num_next  = radicand;
            q_next    = '0;
        end
        else if (ctl.start_div)
        begin
            busy_next = 1'b1;
            mode_next = 1'b1;
            step_next = STEP_W'(QW);
            rem_next  = '0;
            // The dividend scaled by 2^16 sits at the top, so the QW steps use it all.
            num_next  = {dividend, {(SUM_W - TOT_W){1'b0}}};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[REM_W-1])
            begin
                rem_next = trial;
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            num_next  = mode_reg ? {num_reg[SUM_W-2:0], 1'b0}
                                 : {num_reg[SUM_W-3:0], 2'b00};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mode_reg <= mode_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign busy   = busy_reg;
    assign result = q_reg;

    a_no_double_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.start_sqrt && ctl.start_div))
        else $error("square root and division started together");
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start_sqrt || ctl.start_div) |-> !busy_reg)
        else $error("unit started while busy");

endmodule

// File: rtl/triangle_area_cdf_builder_top.sv
// ----------------------------------------------------------------------------
// Triangle area CDF builder
// Appends doubled triangle areas to a prefix store, reads them back as
// Q1.16 fractions of the running total, and clears the store.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  in      | input     | in_valid/ready   | opcode, corners, entry_index
//  out     | output    | out_valid/ready  | cdf_fraction, total, count, status
//
//  An append passes from acceptance to a valid result through a cross
//  product, three squaring phases, a start of the shared unit, 28 root steps
//  on that unit with a finishing check, then accumulate and done.
//  A read runs 52 division steps on the same unit.
//  Clear and unused opcodes go straight to done. One request is worked at a time.
//  Reset clears counts and totals; the prefix memory is not cleared.
//  A stalled result holds in its register; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module triangle_area_cdf_builder_top
    import tacdf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic signed [COORD_BITS-1:0] corner_a_x,
    input  logic signed [COORD_BITS-1:0] corner_a_y,
    input  logic signed [COORD_BITS-1:0] corner_a_z,
    input  logic signed [COORD_BITS-1:0] corner_b_x,
    input  logic signed [COORD_BITS-1:0] corner_b_y,
    input  logic signed [COORD_BITS-1:0] corner_b_z,
    input  logic signed [COORD_BITS-1:0] corner_c_x,
    input  logic signed [COORD_BITS-1:0] corner_c_y,
    input  logic signed [COORD_BITS-1:0] corner_c_z,
    input  logic [IDX_W-1:0]             entry_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FRAC_W-1:0]            cdf_fraction,
    output logic [TOT_W-1:0]             doubled_total_area,
    output logic [CNT_W-1:0]             triangle_count,
    output logic [1:0]                   status
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             ovalid_reg, ovalid_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [1:0]       status_reg, status_next;
    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg;

    logic signed [DIF_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [CRS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [TOT_W-1:0]        prefix_reg;

    logic [TOT_W-1:0] prefix_mem [MAX_TRIANGLES];

    unit_ctl_t        ctl;
    logic             unit_busy;
    logic [SUM_W-1:0] unit_q;
    logic             accept;
    logic             mem_we;
    logic [TOT_W:0]   add_sum;
    logic [TOT_W-1:0] new_total;
    logic [SUM_W-1:0] sq_term;
    logic signed [CRS_W-1:0] sq_in;
    logic [CRS_W-1:0]        sq_mag;
    logic [2*CRS_W-1:0]      sq_prod;

    tacdf_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .radicand (sum_reg),
        .dividend (prefix_reg),
        .divisor  (total_reg),
        .busy     (unit_busy),
        .result   (unit_q)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;

    assign add_sum   = {1'b0, total_reg} + (TOT_W + 1)'(unit_q);
    assign new_total = add_sum[TOT_W] ? TOTAL_MAX : add_sum[TOT_W-1:0];

    // One squaring per cycle over three phases, taken on the magnitude.
    always_comb
    begin
        unique case (phase_reg)
            2'd0:    sq_in = cx_reg;
            2'd1:    sq_in = cy_reg;
            default: sq_in = cz_reg;
        endcase
        sq_mag  = sq_in[CRS_W-1] ? CRS_W'(-sq_in) : CRS_W'(sq_in);
        sq_prod = sq_mag * sq_mag;
        sq_term = SUM_W'(sq_prod);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode_t'(opcode))
                        OP_APPEND: state_next = (count_reg == CNT_W'(MAX_TRIANGLES))
                                                ? S_DONE : S_CROSS;
                        OP_READ:   state_next = ((CNT_W'(entry_index) >= count_reg) ||
                                                 (total_reg == '0)) ? S_DONE : S_RDMEM;
                        default:   state_next = S_DONE;
                    endcase
                end
                phase_next = 2'd0;
            end
            S_CROSS: state_next = S_SQ;
            S_SQ:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd2)
                begin
                    state_next = S_SQRT;
                    phase_next = 2'd0;
                end
            end
            S_SQRT:
            begin
                if (phase_reg == 2'd3 && !unit_busy)
                    state_next = S_ACCUM;
                phase_next = 2'd3;
            end
            S_ACCUM: state_next = S_DONE;
            S_RDMEM:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd1)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (phase_reg == 2'd3 && !unit_busy)
                    state_next = S_DONE;
                phase_next = 2'd3;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        ctl.start_sqrt = (state_reg == S_SQRT) && (phase_reg != 2'd3);
        ctl.start_div  = (state_reg == S_DIV) && (phase_reg != 2'd3);
        mem_we         = (state_reg == S_ACCUM);
        count_next     = count_reg;
        total_next     = total_reg;
        frac_next      = frac_reg;
        status_next    = status_reg;
        ovalid_next    = ovalid_reg && !out_ready;
        if (accept)
        begin
            frac_next   = '0;
            status_next = ST_OK;
            unique case (opcode_t'(opcode))
                OP_APPEND:
                    if (count_reg == CNT_W'(MAX_TRIANGLES))
                        status_next = ST_FULL;
                OP_READ:
                    if (CNT_W'(entry_index) >= count_reg)
                        status_next = ST_RANGE;
                    else if (total_reg == '0)
                        status_next = ST_ZERO_TOT;
                OP_CLEAR:
                begin
                    count_next = '0;
                    total_next = '0;
                end
                default: ;
            endcase
        end
        if (mem_we)
        begin
            total_next = new_total;
            count_next = count_reg + 1'b1;
        end
        if (state_reg == S_DIV && phase_reg == 2'd3 && !unit_busy)
            frac_next = (unit_q > SUM_W'(65536)) ? FRAC_W'(65536) : unit_q[FRAC_W-1:0];
        if (state_reg == S_DONE)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 2'd0;
            count_reg  <= '0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg   <= frac_next;
        status_reg <= status_next;
        if (accept)
        begin
            idx_reg <= entry_index;
            ux_reg  <= DIF_W'(corner_b_x) - DIF_W'(corner_a_x);
            uy_reg  <= DIF_W'(corner_b_y) - DIF_W'(corner_a_y);
            uz_reg  <= DIF_W'(corner_b_z) - DIF_W'(corner_a_z);
            vx_reg  <= DIF_W'(corner_c_x) - DIF_W'(corner_a_x);
            vy_reg  <= DIF_W'(corner_c_y) - DIF_W'(corner_a_y);
            vz_reg  <= DIF_W'(corner_c_z) - DIF_W'(corner_a_z);
        end
        if (state_reg == S_CROSS)
        begin
            cx_reg <= CRS_W'(uy_reg * vz_reg) - CRS_W'(uz_reg * vy_reg);
            cy_reg <= CRS_W'(uz_reg * vx_reg) - CRS_W'(ux_reg * vz_reg);
            cz_reg <= CRS_W'(ux_reg * vy_reg) - CRS_W'(uy_reg * vx_reg);
            sum_reg <= '0;
        end
        if (state_reg == S_SQ)
            sum_reg <= sum_reg + sq_term;
        if (mem_we)
            prefix_mem[count_reg[IDX_W-1:0]] <= new_total;
        if (state_reg == S_RDMEM)
            prefix_reg <= prefix_mem[idx_reg];
    end

    assign out_valid          = ovalid_reg;
    assign cdf_fraction       = frac_reg;
    assign doubled_total_area = total_reg;
    assign triangle_count     = count_reg;
    assign status             = status_reg;

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count beyond capacity");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("finished request produced no result");
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cdf_fraction <= FRAC_W'(65536))
        else $error("fraction above one");

endmodule

// File: tb/tb_triangle_area_cdf_builder_top.sv
// ----------------------------------------------------------------------------
// Triangle area CDF builder testbench
// Sends append, read, clear and unused requests with random gaps on both
// channels. A behavioural model of the prefix store predicts every result,
// and a monitor compares each accepted result field by field.
// ----------------------------------------------------------------------------
module tb_triangle_area_cdf_builder_top;
    import tacdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        opcode_t                      op;
        logic signed [COORD_BITS-1:0] crd [9];
        logic [IDX_W-1:0]             idx;
    } request_t;

    typedef struct {
        logic [FRAC_W-1:0] frac;
        logic [TOT_W-1:0]  total;
        logic [CNT_W-1:0]  count;
        status_t           stat;
    } cdf_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   opcode;
    logic signed [COORD_BITS-1:0] corner_a_x, corner_a_y, corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x, corner_b_y, corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x, corner_c_y, corner_c_z;
    logic [IDX_W-1:0]             entry_index;
    logic                         out_valid;
    logic                         out_ready;
    logic [FRAC_W-1:0]            cdf_fraction;
    logic [TOT_W-1:0]             doubled_total_area;
    logic [CNT_W-1:0]             triangle_count;
    logic [1:0]                   status;

    // Model of the block's state.
    logic [TOT_W-1:0] prefix_model [MAX_TRIANGLES];
    int unsigned      held_model;
    logic [TOT_W-1:0] total_model;

    cdf_result_t pending_results [$];
    int          error_count;
    bit          hold_off_req;

    triangle_area_cdf_builder_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .corner_a_x         (corner_a_x),
        .corner_a_y         (corner_a_y),
        .corner_a_z         (corner_a_z),
        .corner_b_x         (corner_b_x),
        .corner_b_y         (corner_b_y),
        .corner_b_z         (corner_b_z),
        .corner_c_x         (corner_c_x),
        .corner_c_y         (corner_c_y),
        .corner_c_z         (corner_c_z),
        .entry_index        (entry_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .cdf_fraction       (cdf_fraction),
        .doubled_total_area (doubled_total_area),
        .triangle_count     (triangle_count),
        .status             (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [TOT_W-1:0] doubled_area(request_t rq);
        longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] sq_sum;
        logic [127:0] trial;
        logic [63:0]  root;
        ux = longint'(rq.crd[3]) - longint'(rq.crd[0]);
        uy = longint'(rq.crd[4]) - longint'(rq.crd[1]);
        uz = longint'(rq.crd[5]) - longint'(rq.crd[2]);
        vx = longint'(rq.crd[6]) - longint'(rq.crd[0]);
        vy = longint'(rq.crd[7]) - longint'(rq.crd[1]);
        vz = longint'(rq.crd[8]) - longint'(rq.crd[2]);
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        if (cx < 0) cx = -cx;
        if (cy < 0) cy = -cy;
        if (cz < 0) cz = -cz;
        sq_sum = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
        root = '0;
        for (int b = 40; b >= 0; b--)
        begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= sq_sum)
                root = root | (64'd1 << b);
        end
        return root[TOT_W-1:0];
    endfunction

    function automatic cdf_result_t predict_request(request_t rq);
        cdf_result_t      res;
        logic [TOT_W-1:0] area;
        logic [63:0]      quot;
        res.frac = '0;
        res.stat = ST_OK;
        case (rq.op)
            OP_APPEND:
            begin
                if (held_model >= MAX_TRIANGLES)
                    res.stat = ST_FULL;
                else
                begin
                    area = doubled_area(rq);
                    if (area > TOTAL_MAX - total_model)
                        total_model = TOTAL_MAX;
                    else
                        total_model = total_model + area;
                    prefix_model[held_model] = total_model;
                    held_model++;
                end
            end
            OP_READ:
            begin
                if (rq.idx >= held_model)
                    res.stat = ST_RANGE;
                else if (total_model == 0)
                    res.stat = ST_ZERO_TOT;
                else
                begin
                    quot = (64'(prefix_model[rq.idx]) << 16) / 64'(total_model);
                    if (quot > 64'd65536)
                        quot = 64'd65536;
                    res.frac = quot[FRAC_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                held_model  = 0;
                total_model = '0;
            end
            default: ;
        endcase
        res.total = total_model;
        res.count = held_model[CNT_W-1:0];
        return res;
    endfunction

    // Valid stays high between back-to-back requests so it is assigned only once
    // per time step.
    task automatic send_request(request_t rq);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= rq.op;
        corner_a_x  <= rq.crd[0];
        corner_a_y  <= rq.crd[1];
        corner_a_z  <= rq.crd[2];
        corner_b_x  <= rq.crd[3];
        corner_b_y  <= rq.crd[4];
        corner_b_z  <= rq.crd[5];
        corner_c_x  <= rq.crd[6];
        corner_c_y  <= rq.crd[7];
        corner_c_z  <= rq.crd[8];
        entry_index <= rq.idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_request(rq));
    endtask

    function automatic request_t make_request(opcode_t op, int unsigned idx);
        request_t rq;
        rq.op  = op;
        rq.idx = idx[IDX_W-1:0];
        foreach (rq.crd[i])
            rq.crd[i] = COORD_BITS'($urandom());
        return rq;
    endfunction

    function automatic request_t fixed_triangle(int signed v [9]);
        request_t rq;
        rq = make_request(OP_APPEND, 0);
        foreach (rq.crd[i])
            rq.crd[i] = COORD_BITS'(v[i]);
        return rq;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cdf_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("results outstanding", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (cdf_fraction !== want.frac)
                    report_mismatch("cdf_fraction", cdf_fraction, want.frac);
                if (doubled_total_area !== want.total)
                    report_mismatch("doubled_total_area", doubled_total_area, want.total);
                if (triangle_count !== want.count)
                    report_mismatch("triangle_count", triangle_count, want.count);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic test_directed();
        send_request(make_request(OP_READ, 0));
        send_request(make_request(OP_CLEAR, 0));
        send_request(fixed_triangle('{0, 0, 0, 5, 5, 5, 10, 10, 10}));
        send_request(make_request(OP_READ, 0));
        send_request(fixed_triangle('{-2048, -2048, -2048, -2048, -2048, -2048,
                                      -2048, -2048, -2048}));
        send_request(fixed_triangle('{-2048, -2048, -2048, 2047, 2047, -2048,
                                      2047, -2048, 2047}));
        send_request(fixed_triangle('{2047, 2047, 2047, -2048, -2048, 2047,
                                      -2048, 2047, -2048}));
        send_request(fixed_triangle('{-2048, 2047, -2048, 2047, -2048, 2047,
                                      2047, 2047, -2048}));
        send_request(make_request(OP_READ, 0));
        send_request(make_request(OP_READ, 1));
        send_request(make_request(OP_READ, 4));
        send_request(make_request(OP_READ, 5));
        send_request(make_request(OP_READ, 1023));
        send_request(make_request(OP_NONE, 2));
        send_request(make_request(OP_APPEND, 0));
        send_request(make_request(OP_READ, 5));
        send_request(make_request(OP_CLEAR, 0));
        send_request(make_request(OP_READ, 0));
    endtask

    task automatic test_store_full();
        send_request(make_request(OP_CLEAR, 0));
        while (held_model < MAX_TRIANGLES)
            send_request(make_request(OP_APPEND, 0));
        send_request(make_request(OP_APPEND, 0));
        send_request(make_request(OP_READ, 1023));
        send_request(make_request(OP_READ, 512));
        send_request(make_request(OP_READ, $urandom_range(0, 1023)));
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (12)
            send_request(make_request($urandom_range(0, 1) ? OP_APPEND : OP_READ,
                                      $urandom_range(0, 1023)));
    endtask

    task automatic test_random(int count);
        int unsigned pick;
        int unsigned idx;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 999);
            if (held_model > 0)
                idx = $urandom_range(0, held_model - 1);
            else
                idx = 0;
            if (pick < 480)
                send_request(make_request(OP_APPEND, 0));
            else if (pick < 900)
                send_request(make_request(OP_READ, idx));
            else if (pick < 960)
                send_request(make_request(OP_READ, $urandom_range(0, 1023)));
            else if (pick < 985)
                send_request(make_request(OP_NONE, $urandom_range(0, 1023)));
            else
                send_request(make_request(OP_CLEAR, $urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        int wait_cycles;
        error_count  = 0;
        hold_off_req = 1'b0;
        held_model   = 0;
        total_model  = '0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_NONE;
        {corner_a_x, corner_a_y, corner_a_z} = '0;
        {corner_b_x, corner_b_y, corner_b_z} = '0;
        {corner_c_x, corner_c_y, corner_c_z} = '0;
        entry_index  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(40);
        test_store_full();
        test_random(40);

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
